### hdl/wps_pkg.sv
// Shared types and constants of the wildcard pattern scanner.
// No dependencies; every other file of the block except wps_if imports this package.
package wps_pkg;

    localparam int PATTERN_MAX_DEF = 32;
    localparam int LEN_MIN         = 4;
    localparam int QDEPTH          = 4;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;

    localparam logic [15:0] HIT_SAT = 16'hFFFF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PAT0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAT3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MASK   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VOFF   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECT = 3'd7;

    // Result kinds and summary status codes.
    localparam logic       KIND_HIT     = 1'b0;
    localparam logic       KIND_SUMMARY = 1'b1;
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_COUNT     = 2'd1;
    localparam logic [1:0] ST_VALUE     = 2'd2;

    typedef struct packed {
        logic [255:0] pattern;
        logic [31:0]  mask;
        logic [5:0]   length;
        logic [4:0]   voff;
    } t_match_cfg;

    // One classified event handed from the front to the back.
    typedef struct packed {
        logic        hit;
        logic        last;
        logic [31:0] offset;
        logic [31:0] value;
    } t_scan_evt;

    typedef enum logic [1:0] {
        BK_MAIN    = 2'b01,
        BK_SUMMARY = 2'b10
    } t_back_state;

endpackage

### hdl/wps_if.sv
// Handshake interfaces of the wildcard pattern scanner: byte input, result output.
// No dependencies.
interface wps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source(output valid, data_byte, last_byte, input ready);
    modport sink(input valid, data_byte, last_byte, output ready);
endinterface

interface wps_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [31:0] hit_offset;
    logic [31:0] hit_value;
    logic [15:0] hit_total;
    logic [1:0]  scan_status;
    logic        final_result;

    modport source(output valid, result_kind, hit_offset, hit_value, hit_total,
                   scan_status, final_result, input ready);
    modport sink(input valid, result_kind, hit_offset, hit_value, hit_total,
                 scan_status, final_result, output ready);
endinterface

### hdl/wps_front.sv
// Front of the scanner: byte window, masked pattern compare, hit classification.
// Depends on wps_pkg and wps_in_if.
module wps_front #(
    parameter int PATTERN_MAX = wps_pkg::PATTERN_MAX_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    wps_in_if.sink              i_in,
    input  wps_pkg::t_match_cfg i_cfg,
    input  logic                i_q_ready,
    output logic                o_push,
    output wps_pkg::t_scan_evt  o_evt
);
    import wps_pkg::*;

    localparam int LEN_CAP = (PATTERN_MAX < 32) ? PATTERN_MAX : 32;
    localparam int SEEN_W  = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W   = $clog2(PATTERN_MAX);

    logic [7:0]        r_win [PATTERN_MAX];
    logic [7:0]        n_win [PATTERN_MAX];
    logic [SEEN_W-1:0] r_seen;
    logic [SEEN_W-1:0] seen_inc;
    logic [31:0]       r_pos;
    logic [5:0]        len;
    logic [5:0]        lim;
    logic [5:0]        voff;
    logic [6:0]        pos_k;
    logic [6:0]        pos_v;
    logic              enough;
    logic              pat_ok;
    logic              hit;
    logic [31:0]       value;
    logic              accept;

    assign accept     = i_in.valid && i_q_ready;
    assign i_in.ready = i_q_ready;

    always_comb begin
        n_win[0] = i_in.data_byte;
        for (int i = 1; i < PATTERN_MAX; i++) begin
            n_win[i] = r_win[i-1];
        end
    end

    always_comb begin
        if (i_cfg.length < 6'(LEN_MIN)) begin
            len = 6'(LEN_MIN);
        end else if (i_cfg.length > 6'(LEN_CAP)) begin
            len = 6'(LEN_CAP);
        end else begin
            len = i_cfg.length;
        end
        lim  = len - 6'd4;
        voff = ({1'b0, i_cfg.voff} > lim) ? lim : {1'b0, i_cfg.voff};
    end

    assign seen_inc = (r_seen < SEEN_W'(PATTERN_MAX)) ? r_seen + 1'b1 : r_seen;
    assign enough   = 8'(seen_inc) >= 8'(len);

    // Pattern byte k lines up with the byte that arrived len-1-k items ago.
    always_comb begin
        pat_ok = 1'b1;
        pos_k  = '0;
        for (int k = 0; k < 32; k++) begin
            if ((7'(k) < 7'(len)) && !i_cfg.mask[k]) begin
                pos_k = 7'(len) - 7'd1 - 7'(k);
                if (n_win[pos_k[IDX_W-1:0]] != i_cfg.pattern[8*k +: 8]) begin
                    pat_ok = 1'b0;
                end
            end
        end
    end

    always_comb begin
        value = '0;
        pos_v = '0;
        for (int k = 0; k < 4; k++) begin
            pos_v = 7'(len) - 7'd1 - 7'(voff) - 7'(k);
            value[8*k +: 8] = n_win[pos_v[IDX_W-1:0]];
        end
    end

    assign hit = enough && pat_ok;

    assign o_push       = accept && (hit || i_in.last_byte);
    assign o_evt.hit    = hit;
    assign o_evt.last   = i_in.last_byte;
    assign o_evt.offset = r_pos + 32'd1 - 32'(len) + 32'(voff);
    assign o_evt.value  = value;

    // Only bytes received since the last clear are ever compared.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_seen <= '0;
        end else if (accept) begin
            if (i_in.last_byte) begin
                r_pos  <= '0;
                r_seen <= '0;
            end else begin
                r_pos  <= r_pos + 32'd1;
                r_seen <= hit ? '0 : seen_inc;
            end
        end
    end

endmodule

### hdl/wps_queue.sv
// Short event queue between the scanner front and back.
// Depends on wps_pkg.
module wps_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  wps_pkg::t_scan_evt i_evt,
    output logic               o_ready,
    output logic               o_valid,
    output wps_pkg::t_scan_evt o_head,
    input  logic               i_pop
);
    import wps_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_scan_evt        r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = r_count != CNT_W'(QDEPTH);
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### hdl/wps_back.sv
// Back of the scanner: hit counting, value check, result formatting and output register.
// Depends on wps_pkg and wps_out_if.
module wps_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  wps_pkg::t_scan_evt i_head,
    output logic               o_pop,
    input  logic [15:0]        i_expected,
    wps_out_if.source          o_out
);
    import wps_pkg::*;

    t_back_state r_st;
    logic        r_ov;
    logic [15:0] r_cnt;
    logic [31:0] r_first;
    logic        r_diff;
    logic        r_kind;
    logic [31:0] r_off;
    logic [31:0] r_val;
    logic [15:0] r_tot;
    logic [1:0]  r_stat;
    logic        r_fin;

    logic        adv;
    logic        take;
    logic        emit_hit;
    logic [15:0] cnt_inc;
    logic [1:0]  status;

    assign adv  = !r_ov || o_out.ready;
    assign take = adv && i_q_valid;

    always_comb begin
        unique case (r_st)
            BK_MAIN:    emit_hit = i_head.hit;
            BK_SUMMARY: emit_hit = 1'b0;
            default:    emit_hit = 1'b0;
        endcase
    end

    assign cnt_inc = (r_cnt < HIT_SAT) ? r_cnt + 16'd1 : r_cnt;

    always_comb begin
        priority if (r_cnt != i_expected) begin
            status = ST_COUNT;
        end else if (r_diff) begin
            status = ST_VALUE;
        end else begin
            status = ST_OK;
        end
    end

    // A hit on the final byte keeps the event at the head for its summary.
    assign o_pop = take && !(emit_hit && i_head.last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov    <= 1'b0;
            r_st    <= BK_MAIN;
            r_cnt   <= '0;
            r_first <= '0;
            r_diff  <= 1'b0;
        end else begin
            if (adv) begin
                r_ov <= i_q_valid;
            end
            if (take) begin
                if (emit_hit) begin
                    r_cnt <= cnt_inc;
                    if (r_cnt == '0) begin
                        r_first <= i_head.value;
                    end else if (i_head.value != r_first) begin
                        r_diff <= 1'b1;
                    end
                    if (i_head.last) begin
                        r_st <= BK_SUMMARY;
                    end
                end else begin
                    r_cnt   <= '0;
                    r_first <= '0;
                    r_diff  <= 1'b0;
                    r_st    <= BK_MAIN;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (emit_hit) begin
                r_kind <= KIND_HIT;
                r_off  <= i_head.offset;
                r_val  <= i_head.value;
                r_tot  <= cnt_inc;
                r_stat <= ST_OK;
                r_fin  <= !i_head.last;
            end else begin
                r_kind <= KIND_SUMMARY;
                r_off  <= '0;
                r_val  <= r_first;
                r_tot  <= r_cnt;
                r_stat <= status;
                r_fin  <= 1'b1;
            end
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.result_kind  = r_kind;
    assign o_out.hit_offset   = r_off;
    assign o_out.hit_value    = r_val;
    assign o_out.hit_total    = r_tot;
    assign o_out.scan_status  = r_stat;
    assign o_out.final_result = r_fin;

endmodule

### hdl/wildcard_pattern_scanner.sv
// Top level of the wildcard pattern scanner: configuration registers and block wiring.
// Depends on wps_pkg, wps_if, wps_front, wps_queue and wps_back.
//
// Usage:
// The input channel i_in carries one stream byte per item, with last_byte set
// on the final byte. The output channel o_out carries result items: a hit
// report for each non-overlapping match, and one summary item after the final
// byte. When the final byte completes a match, its hit report comes first and
// the summary follows in the next output cycle; final_result marks the last
// result item caused by a byte.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data; the user
// must write it only while the block is idle, as the block does not enforce this.
// Indexes follow the register list, pattern words first. Throughput is one byte
// per cycle while the event queue has room, set by the combinational masked
// compare of the byte window in the front. A result item is written to the event
// queue when its byte is accepted and then loaded into the output register on o_out.
// When the receiver stalls, the output register holds its item, the back stops
// draining the four-entry event queue, and i_in.ready drops once it is full.
// Bytes that cause no result never enter the queue.
// Synchronous reset clears all scan state and loads the register defaults
// (length 4, value offset 0, one expected hit). After each summary the scan
// state returns to its reset values while the registers are kept.
module wildcard_pattern_scanner #(
    parameter int PATTERN_MAX = wps_pkg::PATTERN_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    wps_in_if.sink                          i_in,
    wps_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [wps_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [wps_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import wps_pkg::*;

    t_match_cfg  r_cfg;
    logic [15:0] r_expected;

    logic        q_ready;
    logic        q_valid;
    logic        push;
    logic        pop;
    t_scan_evt   evt;
    t_scan_evt   head;

    // Register file. Every index of the port maps to a register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern <= '0;
            r_cfg.mask    <= '0;
            r_cfg.length  <= 6'(LEN_MIN);
            r_cfg.voff    <= '0;
            r_expected    <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PAT0:   r_cfg.pattern[63:0]    <= i_cfg_data;
                REG_PAT1:   r_cfg.pattern[127:64]  <= i_cfg_data;
                REG_PAT2:   r_cfg.pattern[191:128] <= i_cfg_data;
                REG_PAT3:   r_cfg.pattern[255:192] <= i_cfg_data;
                REG_MASK:   r_cfg.mask             <= i_cfg_data[31:0];
                REG_LENGTH: r_cfg.length           <= i_cfg_data[5:0];
                REG_VOFF:   r_cfg.voff             <= i_cfg_data[4:0];
                REG_EXPECT: r_expected             <= i_cfg_data[15:0];
                default:    r_expected             <= r_expected;
            endcase
        end
    end

    // The front classifies every byte and queues only hits and stream ends.
    wps_front #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (r_cfg),
        .i_q_ready(q_ready),
        .o_push   (push),
        .o_evt    (evt)
    );

    wps_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_evt  (evt),
        .o_ready(q_ready),
        .o_valid(q_valid),
        .o_head (head),
        .i_pop  (pop)
    );

    // The back keeps the hit statistics and owns the output register.
    wps_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_head    (head),
        .o_pop     (pop),
        .i_expected(r_expected),
        .o_out     (o_out)
    );

endmodule

### hdl/wps_checker.sv
// Port-level checks of the wildcard pattern scanner's result channel.
// Depends on wps_pkg; bound to wildcard_pattern_scanner at the end of this file.
module wps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic        i_kind,
    input logic [31:0] i_offset,
    input logic [1:0]  i_status,
    input logic        i_final
);
    import wps_pkg::*;

    // A result item stays offered until it is taken.
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result item dropped before it was taken");

    // Nothing is offered right after a reset cycle.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result offered after reset");

    // A summary closes its byte, carries no offset and a known status.
    a_summary_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == KIND_SUMMARY) |->
            i_final && (i_offset == '0) &&
            ((i_status == ST_OK) || (i_status == ST_COUNT) || (i_status == ST_VALUE)))
        else $error("malformed summary item");

    // A hit report that is not final is followed at once by its summary.
    a_summary_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && (i_kind == KIND_HIT) && !i_final |=>
            i_valid && (i_kind == KIND_SUMMARY))
        else $error("summary missing after hit on final byte");

endmodule

bind wildcard_pattern_scanner wps_checker u_wps_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_kind  (o_out.result_kind),
    .i_offset(o_out.hit_offset),
    .i_status(o_out.scan_status),
    .i_final (o_out.final_result)
);
